[hdl/pgca_pkg.sv]
// Shared constants, register map and averaging functions for the polar grid corner average block.
`default_nettype none

package pgca_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int MAX_AZIMUTH = 1024;

    localparam int COL_W  = $clog2(MAX_AZIMUTH);
    localparam int AZ_W   = COL_W + 1;
    localparam int ROW_W  = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [COL_W-1:0]       t_col;
    typedef logic [ROW_W-1:0]       t_row;
    typedef logic [AZ_W-1:0]        t_azimuth;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_AZIMUTH_COUNT = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_RADIAL_COUNT  = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_SKIP_GHOST    = 4'h8;

    localparam t_azimuth AZ_MIN   = t_azimuth'(2);
    localparam t_azimuth AZ_MAX   = t_azimuth'(MAX_AZIMUTH);
    localparam t_azimuth AZ_RESET = t_azimuth'(MAX_AZIMUTH);
    localparam t_row     RC_RESET = t_row'(1);

    // floor((a + b) / 2) on signed samples
    function automatic t_sample f_half(input t_sample a, input t_sample b);
        logic [SAMPLE_BITS:0] s;
        s = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
        return s[SAMPLE_BITS:1];
    endfunction

    // floor((a + b + c + d) / 4) on signed samples
    function automatic t_sample f_quarter(input t_sample a, input t_sample b,
                                          input t_sample c, input t_sample d);
        logic [SAMPLE_BITS+1:0] s;
        s = {{2{a[SAMPLE_BITS-1]}}, a} + {{2{b[SAMPLE_BITS-1]}}, b}
          + {{2{c[SAMPLE_BITS-1]}}, c} + {{2{d[SAMPLE_BITS-1]}}, d};
        return s[SAMPLE_BITS+1:2];
    endfunction

endpackage

`default_nettype wire

[hdl/pgca_ram.sv]
// Generic single-clock RAM, one write port, one registered read port, read-first.
`default_nettype none

module pgca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

[hdl/polar_grid_corner_average.sv]
// Top level: streaming corner averaging of a polar grid with azimuth wrap.
//
// Input channel (i_valid/o_ready/i_cell_value): grid cells in row-major order,
// radial rows of azimuth_count cells, signed Q16.16.
// Output channel (o_valid/i_ready/o_*): corner items with row/column indices.
// A cell at column c >= 1 yields corner (r,c); the row-ending cell also yields
// (r,0); on the last cell row the same cell also yields the two matching
// corners of the extra last corner row. o_run_last marks the last item of one
// cell, o_grid_last the final item of the grid. Ghost-row cells and column-0
// cells yield nothing.
// A cell is registered in the operand stage, its results in the result buffer.
// Throughput: one cell per cycle while each cell yields one result and the
// receiver takes every item. A cell holds the output port until its results are
// all taken; the column-0 cell after a row end yields nothing, so inner rows keep
// full rate. On the last cell row a cell yields two results (row end: four).
// A stalled receiver fills the result buffer, then the operand stage, then
// drops o_ready; nothing is lost.
// Reset: counters cleared, ghost flag set (skip_ghost_row resets to 1). The
// line store is not cleared: row 0 never reads it. Configuration (APB, pready
// tied high) must be written only while idle; the block does not enforce it.
`default_nettype none

module polar_grid_corner_average (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pgca_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [pgca_pkg::DATA_W-1:0]        pwdata,
    output logic      [pgca_pkg::DATA_W-1:0]        prdata,
    output logic                                    pready,
    // cell input
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [pgca_pkg::SAMPLE_BITS-1:0] i_cell_value,
    // corner output
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [pgca_pkg::SAMPLE_BITS-1:0] o_corner_value,
    output logic      [pgca_pkg::ROW_W-1:0]         o_row_index,
    output logic      [pgca_pkg::COL_W-1:0]         o_column_index,
    output logic                                    o_run_last,
    output logic                                    o_grid_last
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    pgca_pkg::t_azimuth r_azimuth;
    pgca_pkg::t_row     r_radial;
    logic               r_skip;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr)
            pgca_pkg::ADDR_AZIMUTH_COUNT: prdata = pgca_pkg::DATA_W'(r_azimuth);
            pgca_pkg::ADDR_RADIAL_COUNT:  prdata = pgca_pkg::DATA_W'(r_radial);
            pgca_pkg::ADDR_SKIP_GHOST:    prdata = pgca_pkg::DATA_W'(r_skip);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Grid position and stream state
    // ------------------------------------------------------------------
    pgca_pkg::t_col    r_col;
    pgca_pkg::t_row    r_row;
    logic              r_in_ghost;
    pgca_pkg::t_sample r_prev;        // previous cell of this row
    pgca_pkg::t_sample r_row_first;   // column-0 cell of this row
    pgca_pkg::t_sample r_prior_first; // column-0 cell of the row above

    pgca_pkg::t_azimuth az_eff, az_m1;
    pgca_pkg::t_row     rc_m1;
    logic               end_row, last_row, accept;
    pgca_pkg::t_sample  cur, first_eff, up_rd;

    assign accept = i_valid && o_ready;
    assign cur    = pgca_pkg::t_sample'(i_cell_value);

    always_comb begin
        priority if (r_azimuth < pgca_pkg::AZ_MIN) begin
            az_eff = pgca_pkg::AZ_MIN;
        end else if (r_azimuth > pgca_pkg::AZ_MAX) begin
            az_eff = pgca_pkg::AZ_MAX;
        end else begin
            az_eff = r_azimuth;
        end
    end

    assign az_m1     = az_eff - pgca_pkg::t_azimuth'(1);
    assign end_row   = {1'b0, r_col} >= az_m1;
    assign rc_m1     = (r_radial == '0) ? '0 : r_radial - pgca_pkg::t_row'(1);
    assign last_row  = r_row >= rc_m1;
    assign first_eff = (r_col == '0) ? cur : r_row_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_azimuth  <= pgca_pkg::AZ_RESET;
            r_radial   <= pgca_pkg::RC_RESET;
            r_skip     <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
            r_in_ghost <= 1'b1;
        end else begin
            if (cfg_wr) begin
                unique case (paddr)
                    pgca_pkg::ADDR_AZIMUTH_COUNT: r_azimuth <= pwdata[pgca_pkg::AZ_W-1:0];
                    pgca_pkg::ADDR_RADIAL_COUNT:  r_radial  <= pwdata[pgca_pkg::ROW_W-1:0];
                    pgca_pkg::ADDR_SKIP_GHOST: begin
                        r_skip <= pwdata[0];
                        if (r_row == '0 && r_col == '0) begin
                            r_in_ghost <= pwdata[0];
                        end
                    end
                    default: ;
                endcase
            end
            if (accept) begin
                if (end_row) begin
                    r_col <= '0;
                    if (r_in_ghost) begin
                        r_in_ghost <= 1'b0;
                    end else if (last_row) begin
                        r_row      <= '0;
                        r_in_ghost <= r_skip;
                    end else begin
                        r_row <= r_row + pgca_pkg::t_row'(1);
                    end
                end else begin
                    r_col <= r_col + pgca_pkg::t_col'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_in_ghost) begin
            r_prev      <= cur;
            r_row_first <= first_eff;
            if (end_row) begin
                r_prior_first <= first_eff;
            end
        end
    end

    // Line store: entry c holds the row above at column c. Reading and writing
    // the same column on accept gives the old row (read-first).
    pgca_ram #(
        .WIDTH(pgca_pkg::SAMPLE_BITS),
        .DEPTH(pgca_pkg::MAX_AZIMUTH)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (accept && !r_in_ghost),
        .i_waddr(r_col),
        .i_wdata(cur),
        .i_re   (accept),
        .i_raddr(r_col),
        .o_rdata(up_rd)
    );

    // ------------------------------------------------------------------
    // Operand stage: the line store read lands here alongside the operands
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    pgca_pkg::t_sample r_s1_cur, r_s1_prev, r_s1_first, r_s1_prior, r_s1_up_prev;
    pgca_pkg::t_col    r_s1_col;
    pgca_pkg::t_row    r_s1_row;
    logic              r_s1_end, r_s1_last;
    logic              ob_free, ob_load;

    assign o_ready = !r_s1_valid || ob_free;
    assign ob_load = r_s1_valid && ob_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            // column-0 and ghost cells yield no result
            r_s1_valid <= !r_in_ghost && (r_col != '0);
        end else if (ob_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur     <= cur;
            r_s1_prev    <= r_prev;
            r_s1_first   <= first_eff;
            r_s1_prior   <= r_prior_first;
            r_s1_up_prev <= up_rd;  // row above at column c-1, read by the previous cell
            r_s1_col     <= r_col;
            r_s1_row     <= r_row;
            r_s1_end     <= end_row;
            r_s1_last    <= last_row;
        end
    end

    pgca_pkg::t_sample v_mid, v_wrap, v_last_mid, v_last_wrap;

    always_comb begin
        v_last_mid  = pgca_pkg::f_half(r_s1_cur, r_s1_prev);
        v_last_wrap = pgca_pkg::f_half(r_s1_cur, r_s1_first);
        if (r_s1_row == '0) begin
            v_mid  = v_last_mid;
            v_wrap = v_last_wrap;
        end else begin
            v_mid  = pgca_pkg::f_quarter(r_s1_cur, r_s1_prev, up_rd, r_s1_up_prev);
            v_wrap = pgca_pkg::f_quarter(r_s1_cur, r_s1_first, r_s1_prior, up_rd);
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: up to four corners of one cell, sent lowest slot first.
    // Slots: (r,c), (r,0), (r+1,c), (r+1,0).
    // ------------------------------------------------------------------
    logic [3:0]        r_ob_mask;
    pgca_pkg::t_sample r_ob_val [4];
    pgca_pkg::t_row    r_ob_row;
    pgca_pkg::t_col    r_ob_col;
    logic              r_ob_grid;

    logic [1:0] sel;
    logic [3:0] sel_bit;
    logic       pop, last_one;

    always_comb begin
        priority if (r_ob_mask[0]) begin
            sel = 2'd0;
        end else if (r_ob_mask[1]) begin
            sel = 2'd1;
        end else if (r_ob_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    assign sel_bit  = 4'b0001 << sel;
    assign last_one = (r_ob_mask & (r_ob_mask - 4'd1)) == 4'd0;
    assign pop      = o_valid && i_ready;
    assign ob_free  = (r_ob_mask == 4'd0) || (pop && last_one);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_mask <= 4'd0;
        end else if (ob_load) begin
            r_ob_mask <= {r_s1_last && r_s1_end, r_s1_last, r_s1_end, 1'b1};
        end else if (pop) begin
            r_ob_mask <= r_ob_mask & ~sel_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_load) begin
            r_ob_val[0] <= v_mid;
            r_ob_val[1] <= v_wrap;
            r_ob_val[2] <= v_last_mid;
            r_ob_val[3] <= v_last_wrap;
            r_ob_row    <= r_s1_row;
            r_ob_col    <= r_s1_col;
            r_ob_grid   <= r_s1_last && r_s1_end;
        end
    end

    assign o_valid        = r_ob_mask != 4'd0;
    assign o_corner_value = r_ob_val[sel];
    assign o_row_index    = sel[1] ? r_ob_row + pgca_pkg::t_row'(1) : r_ob_row;
    assign o_column_index = sel[0] ? '0 : r_ob_col;
    assign o_run_last     = last_one;
    assign o_grid_last    = last_one && r_ob_grid;

`ifndef NO_ASSERTIONS
    // a grid ends on the last item of its cell
    a_grid_last_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grid_last) |-> o_run_last)
        else $error("grid_last without run_last");

    // a ghost row is only ever the first row of a grid
    a_ghost_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ghost |-> (r_row == '0))
        else $error("ghost row flag set away from row zero");

    // ghost cells never reach the operand stage
    a_ghost_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && r_in_ghost) |=> !r_s1_valid)
        else $error("ghost cell entered operand stage");

    // every cell handed to the result buffer shows at least one item next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ob_load |=> (o_valid && r_ob_mask[0]))
        else $error("result buffer load produced no item");
`endif

endmodule

`default_nettype wire

[tb/pgca_corner_checker.sv]
// Corner checker: mirrors register writes, predicts corner items from accepted cells, compares.
module pgca_corner_checker
    import pgca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              i_valid,
    input  logic              o_ready,
    input  t_sample           i_cell_value,
    input  logic              o_valid,
    input  logic              i_ready,
    input  t_sample           o_corner_value,
    input  t_row              o_row_index,
    input  t_col              o_column_index,
    input  logic              o_run_last,
    input  logic              o_grid_last,
    output int                mismatch_count,
    output int                corners_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_sample value;
        t_row    row;
        t_col    col;
        logic    run_last;
        logic    grid_last;
    } corner_t;

    corner_t  expected_corners[$];

    // shadow of the block's state and registers
    t_sample  line_store [MAX_AZIMUTH];
    t_sample  prev_cell;
    t_sample  row_first;
    t_sample  prior_row_first;
    t_row     row_cnt;
    int       col_cnt;
    logic     in_ghost;
    t_azimuth az_reg;
    t_row     rc_reg;
    logic     skip_reg;
    int       fail_count;

    // floor of the mean, on sign-extended sums
    function automatic t_sample pair_mean(input t_sample a, input t_sample b);
        longint sum;
        sum = longint'($signed(a)) + longint'($signed(b));
        return t_sample'(sum >>> 1);
    endfunction

    function automatic t_sample quad_mean(input t_sample a, input t_sample b,
                                          input t_sample c, input t_sample d);
        longint sum;
        sum = longint'($signed(a)) + longint'($signed(b))
            + longint'($signed(c)) + longint'($signed(d));
        return t_sample'(sum >>> 2);
    endfunction

    function automatic corner_t make_corner(input t_sample v, input t_row r, input int c);
        corner_t item;
        item.value     = v;
        item.row       = r;
        item.col       = t_col'(c);
        item.run_last  = 1'b0;
        item.grid_last = 1'b0;
        return item;
    endfunction

    // one accepted cell -> zero to four corner items, in output order
    function automatic void predict_corners(input t_sample cur);
        int      az;
        int      rc;
        int      c;
        int      n;
        int      k;
        t_row    r;
        logic    row_end;
        logic    grid_row;
        corner_t batch [4];

        az = (az_reg < AZ_MIN) ? int'(AZ_MIN) : (az_reg > AZ_MAX) ? int'(AZ_MAX) : int'(az_reg);
        rc = (rc_reg == 0) ? 1 : int'(rc_reg);
        c  = (col_cnt >= MAX_AZIMUTH) ? MAX_AZIMUTH - 1 : col_cnt;
        r  = row_cnt;
        n  = 0;
        row_end = (c >= az - 1);

        if (in_ghost) begin
            if (row_end) begin
                col_cnt  = 0;
                in_ghost = 1'b0;
            end else begin
                col_cnt = c + 1;
            end
            return;
        end

        grid_row = (int'(r) >= rc - 1);
        if (c == 0)
            row_first = cur;

        if (c >= 1) begin
            batch[n] = make_corner((r == 0) ? pair_mean(cur, prev_cell)
                                   : quad_mean(cur, prev_cell, line_store[c], line_store[c-1]),
                                   r, c);
            n++;
        end
        if (row_end) begin
            batch[n] = make_corner((r == 0) ? pair_mean(cur, row_first)
                                   : quad_mean(cur, row_first, prior_row_first, line_store[c]),
                                   r, 0);
            n++;
        end
        if (grid_row) begin
            if (c >= 1) begin
                batch[n] = make_corner(pair_mean(cur, prev_cell), t_row'(r + 1), c);
                n++;
            end
            if (row_end) begin
                batch[n] = make_corner(pair_mean(cur, row_first), t_row'(r + 1), 0);
                n++;
            end
        end

        if (c >= 1)
            line_store[c-1] = prev_cell;
        if (row_end)
            line_store[c] = cur;
        prev_cell = cur;

        if (row_end) begin
            prior_row_first = row_first;
            col_cnt = 0;
            if (grid_row) begin
                row_cnt  = '0;
                in_ghost = skip_reg;
            end else begin
                row_cnt = t_row'(r + 1);
            end
        end else begin
            col_cnt = c + 1;
        end

        if (n > 0) begin
            batch[n-1].run_last  = 1'b1;
            batch[n-1].grid_last = row_end && grid_row;
        end
        for (k = 0; k < n; k++)
            expected_corners.push_back(batch[k]);
    endfunction

    always @(posedge i_clk) begin
        corner_t want;
        if (!i_rst_n) begin
            expected_corners.delete();
            prev_cell       = '0;
            row_first       = '0;
            prior_row_first = '0;
            row_cnt         = '0;
            col_cnt         = 0;
            az_reg          = AZ_RESET;
            rc_reg          = RC_RESET;
            skip_reg        = 1'b1;
            in_ghost        = 1'b1;
        end else begin
            // output first: nothing accepted at this edge can come out at it
            if (o_valid && i_ready) begin
                if (expected_corners.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected corner item: value %0d row %0d col %0d",
                                 $signed(o_corner_value), o_row_index, o_column_index);
                    fail_count++;
                end else begin
                    want = expected_corners.pop_front();
                    if (o_corner_value !== want.value || o_row_index !== want.row ||
                        o_column_index !== want.col || o_run_last !== want.run_last ||
                        o_grid_last !== want.grid_last) begin
                        if (fail_count < 10)
                            $display({"corner mismatch: expected %0d row %0d col %0d ",
                                      "run_last %0b grid_last %0b, got %0d row %0d col %0d ",
                                      "run_last %0b grid_last %0b"},
                                     $signed(want.value), want.row, want.col,
                                     want.run_last, want.grid_last,
                                     $signed(o_corner_value), o_row_index, o_column_index,
                                     o_run_last, o_grid_last);
                        fail_count++;
                    end
                end
            end

            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_AZIMUTH_COUNT: az_reg = pwdata[AZ_W-1:0];
                    ADDR_RADIAL_COUNT:  rc_reg = pwdata[ROW_W-1:0];
                    ADDR_SKIP_GHOST: begin
                        skip_reg = pwdata[0];
                        // ghost flag only reloads at a grid boundary
                        if (row_cnt == 0 && col_cnt == 0)
                            in_ghost = pwdata[0];
                    end
                    default: ;
                endcase
            end

            if (i_valid && o_ready)
                predict_corners(i_cell_value);
        end
        mismatch_count  <= fail_count;
        corners_pending <= expected_corners.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top: clock, reset, register setup, cell stimulus, corner back-pressure, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pgca_pkg::*;

    localparam int RANDOM_CELLS  = 180;
    localparam int PARTIAL_ROW   = 24;   // cells sent into a 1024-wide row
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 8;    // > pipeline latency, covers cells with no result
    localparam int HOLD_CYCLES   = 80;   // long enough to back up into the input

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    t_sample           i_cell_value = '0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    t_sample           o_corner_value;
    t_row              o_row_index;
    t_col              o_column_index;
    logic              o_run_last;
    logic              o_grid_last;

    int mismatch_count;
    int corners_pending;
    int random_cells  = 0;
    int hold_request  = 0;   // cycles the sink should hold off, picked up by the sink
    bit send_steady   = 1'b0;
    bit recv_steady   = 1'b0;

    // Hand-picked cells: saturated rows, then odd sums around zero to hit floor rounding.
    t_sample edge_cells [14] = '{
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
        32'h8000_0000, 32'h7FFF_FFFF
    };

    polar_grid_corner_average dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cell_value   (i_cell_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_corner_value (o_corner_value),
        .o_row_index    (o_row_index),
        .o_column_index (o_column_index),
        .o_run_last     (o_run_last),
        .o_grid_last    (o_grid_last)
    );

    pgca_corner_checker corner_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cell_value    (i_cell_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_corner_value  (o_corner_value),
        .o_row_index     (o_row_index),
        .o_column_index  (o_column_index),
        .o_run_last      (o_run_last),
        .o_grid_last     (o_grid_last),
        .mismatch_count  (mismatch_count),
        .corners_pending (corners_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mix of extremes, small values around zero, whole Q16.16 numbers and raw random bits.
    function automatic t_sample random_cell();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return t_sample'(int'($urandom_range(0, 8)) - 4);
            3:       return {16'($urandom()), 16'h0000};
            default: return t_sample'($urandom());
        endcase
    endfunction

    // Setup phase, access phase (write lands here), then an idle phase.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering cells and wait until every predicted corner has been taken.
    // The extra edge lets the checker's count include the last accepted cell.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (corners_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers are only touched with the block idle.
    task automatic configure(input int az, input int rc, input int skip);
        drain();
        apb_write(ADDR_AZIMUTH_COUNT, az);
        apb_write(ADDR_RADIAL_COUNT, rc);
        apb_write(ADDR_SKIP_GHOST, skip);
        // some phases run without any gaps on one or both sides
        send_steady = ($urandom_range(0, 3) == 0);
        recv_steady = ($urandom_range(0, 3) == 0);
    endtask

    // Valid stays high back to back when the next gap is zero, so it is
    // never dropped and raised in the same step.
    task automatic send_cell(input t_sample value);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cell_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_cells(input int count);
        repeat (count) send_cell(random_cell());
    endtask

    // Corner sink: random stall before each item, plus one long hold-off on request.
    initial begin : corner_sink
        int stall;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                i_ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end
            stall = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        int az;
        int rc;
        int skip;
        int rows;
        int k;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 1024-wide azimuth with the ghost row skipped. Part of
        // the ghost row goes in; the short azimuth written next closes it at
        // the following cell, since the ghost flag is kept mid-row.
        send_cells(PARTIAL_ROW);

        // Saturated and rounding cases on a 4x3 grid.
        configure(4, 3, 1);
        send_cells(1);
        for (k = 0; k < 12; k++)
            send_cell(edge_cells[k]);

        // Azimuth below range acts as 2, zero radial count acts as 1.
        configure(1, 0, 0);
        send_cell(edge_cells[12]);
        send_cell(edge_cells[13]);

        // Radial count at its top, then cut down mid-grid: the next row ends
        // the grid. The ghost flag written mid-grid only applies to the next grid.
        configure(5, 16'hFFFF, 0);
        send_cells(15);
        drain();
        apb_write(ADDR_RADIAL_COUNT, 2);
        apb_write(ADDR_SKIP_GHOST, 1);
        send_cells(5);
        send_cells(5 + 10);

        // Back-pressure: sink holds off while cells keep coming at full rate.
        configure(6, 8, 0);
        send_steady  = 1'b1;
        hold_request = HOLD_CYCLES;
        send_cells(48);

        // Azimuth above range clamps to the maximum width: part of one row,
        // then a two-wide azimuth ends the row and the grid at the next cell.
        configure(2047, 1, 0);
        send_cells(PARTIAL_ROW);
        configure(2, 1, 0);
        send_cells(1);

        // Random grids, mostly small; a third of multi-row phases cut one grid short.
        while (random_cells < RANDOM_CELLS) begin
            case ($urandom_range(0, 9))
                0:       az = 0;
                1:       az = 1;
                2, 3:    az = 2;
                default: az = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       rc = 0;
                1, 2:    rc = 1;
                default: rc = $urandom_range(2, 5);
            endcase
            skip = $urandom_range(0, 1);
            configure(az, rc, skip);
            if (az < 2)
                az = 2;
            if (rc < 1)
                rc = 1;

            repeat ($urandom_range(1, 3)) begin
                if (skip)
                    send_cells(az);      // ghost row, not counted
                send_cells(az * rc);
                random_cells += az * rc;
            end

            if (rc >= 2 && $urandom_range(0, 2) == 0) begin
                if (skip)
                    send_cells(az);
                rows = $urandom_range(1, rc - 1);
                send_cells(rows * az);
                drain();
                // new count never above the rows done, so the next row closes the grid
                apb_write(ADDR_RADIAL_COUNT, $urandom_range(0, rows));
                skip = $urandom_range(0, 1);
                apb_write(ADDR_SKIP_GHOST, skip);
                send_cells(az);
                random_cells += (rows + 1) * az;
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Several times the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
